FILE: hw/rtl/pss_pkg.sv
package pss_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int TIME_W         = 32;
  localparam int PERIOD_W       = 16;
  localparam int MASK_W         = 16;
  localparam int KIND_W         = 2;
  localparam int IDX_W          = 4;
  // slots reachable by a load request (slot_index width)
  localparam int LOAD_SLOTS     = 1 << IDX_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHECK = 2'd0,
    KIND_ALIGN = 2'd1,
    KIND_LOAD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_t;

  // result of one slot evaluation
  typedef struct packed {
    logic              fire;
    logic [TIME_W-1:0] next_time;
  } slot_upd_t;

endpackage

FILE: hw/rtl/pss_slot_unit.sv
module pss_slot_unit (
  input  logic [pss_pkg::TIME_W-1:0]   now_time,
  input  logic [pss_pkg::TIME_W-1:0]   last_time,
  input  logic [pss_pkg::PERIOD_W-1:0] period,
  output pss_pkg::slot_upd_t           upd
);
  import pss_pkg::*;

  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] period_ext;
  logic [TIME_W-1:0] period_x2;
  logic              snap;

  assign elapsed    = now_time - last_time;
  assign period_ext = TIME_W'(period);
  // snap threshold: twice the period
  assign period_x2  = TIME_W'({period, 1'b0});
  assign snap       = elapsed > period_x2;

  always_comb begin
    upd.fire      = elapsed >= period_ext;
    upd.next_time = last_time;
    if (upd.fire) begin
      upd.next_time = snap ? now_time : (last_time + period_ext);
    end
  end

endmodule

FILE: hw/rtl/periodic_slot_scheduler.sv
// Check request: one slot is evaluated per cycle by the shared subtract/compare
//   unit, then the finished mask waits in ST_WAIT until the output register
//   frees up; in_ready stays low until that mask is loaded into out_*.
// Align and load requests: go straight to ST_WAIT and return an empty mask.
// A new request is taken while the previous result still sits in out_*.
// Reset (rst_n low, synchronous): slot table cleared, no result pending.
module periodic_slot_scheduler #(
  parameter int SLOT_COUNT = pss_pkg::SLOT_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pss_pkg::KIND_W-1:0]   in_kind,
  input  logic [pss_pkg::TIME_W-1:0]   in_now_time,
  input  logic [pss_pkg::IDX_W-1:0]    in_slot_index,
  input  logic [pss_pkg::PERIOD_W-1:0] in_load_period,
  input  logic                         in_load_enable,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pss_pkg::MASK_W-1:0]   out_fire_mask
);
  import pss_pkg::*;

  localparam int CNT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // sequencer
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;      // slot being evaluated
  logic [TIME_W-1:0] now_r;               // time of the running check
  logic [MASK_W-1:0] mask_r, mask_nxt;    // fire mask being built

  // slot table
  logic [TIME_W-1:0]   last_r   [SLOT_COUNT];
  logic [PERIOD_W-1:0] period_r [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] enable_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] out_mask_r;
  logic              out_load;

  logic      in_acc;
  logic      out_free;
  logic      run_step;
  logic      last_slot;
  slot_upd_t upd;

  assign in_ready      = (state_r == ST_IDLE);
  assign in_acc        = in_valid && in_ready;
  assign out_free      = !out_valid_r || out_ready;
  assign run_step      = (state_r == ST_RUN);
  assign last_slot     = (cnt_r == CNT_W'(SLOT_COUNT - 1));
  assign out_valid     = out_valid_r;
  assign out_fire_mask = out_mask_r;

  // shared elapsed-time / compare / advance unit, one slot per cycle
  pss_slot_unit u_unit (
    .now_time  (now_r),
    .last_time (last_r[cnt_r]),
    .period    (period_r[cnt_r]),
    .upd       (upd)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mask_nxt      = mask_r;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt  = '0;
          mask_nxt = '0;
          // align/load/unused kinds finish at once with an empty mask
          state_nxt = (in_kind == KIND_CHECK) ? ST_RUN : ST_WAIT;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        // only the first MASK_W slots have a bit in the mask
        for (int j = 0; j < MASK_W; j++) begin
          if (j < SLOT_COUNT && 32'(cnt_r) == j && upd.fire && enable_r[cnt_r]) begin
            mask_nxt[j] = 1'b1;
          end
        end
        if (last_slot) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // hold the finished mask until the output register frees up
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r <= in_now_time;
    end
    if (out_load) begin
      out_mask_r <= mask_r;
    end
  end

  // slot table: reset clears, align writes all timestamps, load writes one
  // slot's period/enable, a check step rewrites the visited timestamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < SLOT_COUNT; j++) begin
        last_r[j]   <= '0;
        period_r[j] <= '0;
      end
      enable_r <= '0;
    end else begin
      if (in_acc && in_kind == KIND_ALIGN) begin
        for (int j = 0; j < SLOT_COUNT; j++) begin
          last_r[j] <= in_now_time;
        end
      end
      if (in_acc && in_kind == KIND_LOAD) begin
        // index past the table is dropped
        for (int j = 0; j < SLOT_COUNT; j++) begin
          if (j < LOAD_SLOTS && 32'(in_slot_index) == j) begin
            period_r[j] <= in_load_period;
            enable_r[j] <= in_load_enable;
          end
        end
      end
      if (run_step) begin
        last_r[cnt_r] <= upd.next_time;
      end
    end
  end

endmodule

FILE: hw/rtl/pss_checker.sv
module pss_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [pss_pkg::KIND_W-1:0]   in_kind,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pss_pkg::MASK_W-1:0]   out_fire_mask
);
  import pss_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;   // requests accepted but not yet answered

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fire_mask))
    else $error("result changed while stalled");

  // no result without a request behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without pending request");

  // at most one request in flight plus one waiting result
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many pending requests");

  // a check occupies the slot sequencer
  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_kind == KIND_CHECK |=> !in_ready)
    else $error("request taken during check sweep");

endmodule

bind periodic_slot_scheduler pss_checker u_pss_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_kind       (in_kind),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_fire_mask (out_fire_mask)
);
